>>> rtl/core/acfb_pkg.sv
// Shared types, constants and AES round functions for the CFB cipher block.
// Used by acfb_key_sched and aes256_cfb_cipher; depends on nothing.
`default_nettype none
package acfb_pkg;

    localparam int ROUNDS   = 14;
    localparam int RK_DEPTH = ROUNDS + 1;
    localparam int RK_AW    = $clog2(RK_DEPTH);

    // Configuration register indexes
    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_IVH  = 3'd4;
    localparam logic [2:0] REG_IVL  = 3'd5;
    localparam logic [2:0] REG_MODE = 3'd6;

    localparam logic [RK_AW-1:0] RK_LAST = RK_AW'(ROUNDS);

    localparam logic [7:0] POLY_RED = 8'h1b;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } acfb_state_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? POLY_RED : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // SubBytes, ShiftRows and, unless last, MixColumns; byte 0 in the top bits
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] o [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] res;
        for (int i = 0; i < 16; i++)
            b[i] = s[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[r+4*c] = SBOX[b[r + 4*((c + r) & 3)]];
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = o[4*c]; a1 = o[4*c+1]; a2 = o[4*c+2]; a3 = o[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                o[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                o[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                o[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                o[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
            res[127-8*i -: 8] = o[i];
        aes_round = res;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/acfb_key_sched.sv
// AES-256 key expansion into a 15-entry round key memory, one round key a cycle.
// Depends on acfb_pkg.
`default_nettype none
module acfb_key_sched import acfb_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [255:0]     key,
    input  wire logic [RK_AW-1:0] rd_addr,
    output logic      [127:0]     rd_data,
    output logic                  busy
);

    logic [127:0]     rk_mem [RK_DEPTH];
    logic [127:0]     rd_data_reg;
    logic             active_reg, active_next;
    logic [RK_AW-1:0] cnt_reg, cnt_next;
    logic [127:0]     prev2_reg, prev1_reg;
    logic [127:0]     rk_new;
    logic [31:0]      t;
    logic [31:0]      w0, w1, w2, w3;
    logic [7:0]       rcon;

    always_comb
    begin
        rcon = 8'h01 << (cnt_reg[RK_AW-1:1] - 3'd1);
        if (!cnt_reg[0])
            t = sub_word({prev1_reg[23:0], prev1_reg[31:24]}) ^ {rcon, 24'h0};
        else
            t = sub_word(prev1_reg[31:0]);
        w0 = prev2_reg[127:96] ^ t;
        w1 = prev2_reg[95:64] ^ w0;
        w2 = prev2_reg[63:32] ^ w1;
        w3 = prev2_reg[31:0] ^ w2;
        if (cnt_reg == '0)
            rk_new = key[255:128];
        else if (cnt_reg == RK_AW'(1))
            rk_new = key[127:0];
        else
            rk_new = {w0, w1, w2, w3};
    end

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
        end
        else if (active_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == RK_LAST)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (active_reg && !start)
        begin
            rk_mem[cnt_reg] <= rk_new;
            prev2_reg       <= prev1_reg;
            prev1_reg       <= rk_new;
        end
        rd_data_reg <= rk_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = active_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> cnt_reg <= RK_LAST)
        else $error("key schedule counter out of range");
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !start && cnt_reg == RK_LAST) |=> !active_reg)
        else $error("key schedule did not stop");
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (active_reg && cnt_reg == '0))
        else $error("key schedule did not restart");

endmodule
`default_nettype wire

>>> rtl/core/aes256_cfb_cipher.sv
// Top level of the AES-256 CFB-128 cipher: handshakes, registers, round datapath.
// Depends on acfb_pkg and acfb_key_sched.
`default_nettype none
// Each 16-byte word passes from acceptance to result through the initial key
// addition and the 14 rounds, each round key read from the round key memory in
// the cycle before its use. The CFB feedback closes at the end of the last
// round, and the next word is accepted in the cycle after that, so no word is
// taken before the previous word's last round is done. A result waits in an
// output register while the next word is worked on; a result still waiting
// when the next last round ends holds that round until it is taken. After
// reset and after each write to a key register the key expansion fills the
// round key memory; meanwhile neither words nor configuration writes are taken.
module aes256_cfb_cipher import acfb_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        start_of_message,
    input  wire logic [63:0] data_high,
    input  wire logic [63:0] data_low,
    input  wire logic [4:0]  byte_count,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [63:0] result_high,
    output logic      [63:0] result_low,
    output logic      [4:0]  valid_bytes,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    acfb_state_t      st_reg, st_next;
    logic [RK_AW-1:0] rnd_reg, rnd_next;
    logic [RK_AW-1:0] rd_addr;
    logic [127:0]     rk_q;
    logic             ks_busy;
    logic             ks_start;
    logic             cfg_fire, in_fire, finish;

    logic [255:0]     key_reg;
    logic [127:0]     iv_reg;
    logic             mode_reg;
    logic [127:0]     fb_reg;
    logic [127:0]     aes_reg;
    logic [127:0]     data_reg;
    logic [4:0]       cnt_reg;
    logic             out_valid_reg, out_valid_next;
    logic [127:0]     result_reg;
    logic [4:0]       vb_reg;

    logic [127:0]     ks_word, res_word, fb_word;

    assign cfg_ready = (st_reg == ST_IDLE) && !ks_busy;
    assign in_ready  = (st_reg == ST_IDLE) && !ks_busy;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;
    assign ks_start  = cfg_fire && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
                                    cfg_index == REG_KEY2 || cfg_index == REG_KEY3);
    // last round completes only when the output register is free or taken this cycle
    assign finish    = (st_reg == ST_RUN) && (rnd_reg == RK_LAST) &&
                       (!out_valid_reg || out_ready);

    // prefetch the next round key; hold on the last one while stalled
    assign rd_addr = in_fire ? '0 : ((rnd_reg == RK_LAST) ? RK_LAST : rnd_reg + 1'b1);

    acfb_key_sched u_keys (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ks_start),
        .key     (key_reg),
        .rd_addr (rd_addr),
        .rd_data (rk_q),
        .busy    (ks_busy)
    );

    always_comb
    begin
        ks_word = aes_round(aes_reg, 1'b1) ^ rk_q;
        for (int j = 0; j < 16; j++)
        begin
            if (5'(j) < cnt_reg)
            begin
                res_word[127-8*j -: 8] = data_reg[127-8*j -: 8] ^ ks_word[127-8*j -: 8];
                fb_word[127-8*j -: 8]  = mode_reg ? data_reg[127-8*j -: 8]
                                                  : res_word[127-8*j -: 8];
            end
            else
            begin
                res_word[127-8*j -: 8] = 8'h00;
                fb_word[127-8*j -: 8]  = fb_reg[127-8*j -: 8];
            end
        end
    end

    always_comb
    begin
        st_next        = st_reg;
        rnd_next       = rnd_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    st_next  = ST_RUN;
                    rnd_next = '0;
                end
            end
            ST_RUN:
            begin
                if (rnd_reg != RK_LAST)
                    rnd_next = rnd_reg + 1'b1;
                else if (finish)
                begin
                    st_next        = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
            iv_reg        <= '0;
            mode_reg      <= 1'b0;
            fb_reg        <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_fire)
            begin
                case (cfg_index)
                    REG_KEY0: key_reg[255:192] <= cfg_data;
                    REG_KEY1: key_reg[191:128] <= cfg_data;
                    REG_KEY2: key_reg[127:64]  <= cfg_data;
                    REG_KEY3: key_reg[63:0]    <= cfg_data;
                    REG_IVH:  iv_reg[127:64]   <= cfg_data;
                    REG_IVL:  iv_reg[63:0]     <= cfg_data;
                    REG_MODE: mode_reg         <= cfg_data[0];
                    default:  ;
                endcase
            end
            if (in_fire && start_of_message)
                fb_reg <= iv_reg;
            else if (finish)
                fb_reg <= fb_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            data_reg <= {data_high, data_low};
            cnt_reg  <= byte_count;
        end
        if (st_reg == ST_RUN && rnd_reg != RK_LAST)
        begin
            if (rnd_reg == '0)
                aes_reg <= fb_reg ^ rk_q;
            else
                aes_reg <= aes_round(aes_reg, 1'b0) ^ rk_q;
        end
        if (finish)
        begin
            result_reg <= res_word;
            vb_reg     <= cnt_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_high = result_reg[127:64];
    assign result_low  = result_reg[63:0];
    assign valid_bytes = vb_reg;

    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (st_reg == ST_RUN && rnd_reg == '0))
        else $error("accepted word did not start the rounds");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready || cfg_ready) |-> (!ks_busy && st_reg == ST_IDLE))
        else $error("handshake open while busy");
    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(rnd_reg) == RK_LAST)
        else $error("result shown before the last round");
    a_key_expands: assert property (@(posedge clk) disable iff (!rst_n)
        ks_start |=> ks_busy)
        else $error("key write did not start expansion");

endmodule
`default_nettype wire
